/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the sde_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* hdl/sde_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite draw engine package
// Shared types, register codes and the fixed RGB565 palette.
// ----------------------------------------------------------------------------
package sde_pkg;

  localparam int STORE_AW = 14;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_SWAP_BYTES    = 2'd2,
    CFG_PALETTE_REMAP = 2'd3
  } cfg_reg_t;

  localparam logic [8:0]  RST_SCREEN_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_SCREEN_HEIGHT = 9'd150;
  localparam logic        RST_SWAP_BYTES    = 1'b0;
  localparam logic [63:0] RST_PALETTE_REMAP = 64'hFEDC_BA98_7654_3210;

  localparam logic [15:0] PALETTE [16] = '{
    16'h0000, 16'h194A, 16'h792A, 16'h0429, 16'hAB49, 16'h5AEB, 16'hC618, 16'hFFDF,
    16'hF809, 16'hFD20, 16'hFFE4, 16'h07E4, 16'h2D7F, 16'h83B3, 16'hFBB5, 16'hFE75
  };

  typedef struct packed {
    logic [3:0] index;
    logic       swap;
  } color_req_t;

endpackage

/* hdl/sde_color_unit.sv */
// ----------------------------------------------------------------------------
// Sprite draw engine color unit
// Remaps a 4-bit sheet index, looks it up in the palette and optionally swaps bytes.
// ----------------------------------------------------------------------------
module sde_color_unit
  import sde_pkg::*;
(
  input  logic [63:0] remap,
  input  color_req_t  req,
  output logic [15:0] color
);

  logic [3:0]  mapped;
  logic [15:0] base_color;

  assign mapped     = remap[{req.index, 2'b00} +: 4];
  assign base_color = PALETTE[mapped];
  assign color      = req.swap ? {base_color[7:0], base_color[15:8]} : base_color;

endmodule

/* hdl/sprite_draw_engine_top.sv */
// ----------------------------------------------------------------------------
// Sprite draw engine
// Loads a 4-bit sprite sheet and walks sprites into clipped RGB565 writes.
// ----------------------------------------------------------------------------
// A load transaction writes one sheet pixel in its accept cycle and keeps busy
// low. A draw with an out-of-range id gives its single result in the next
// cycle. A valid draw first locates the sprite on the sheet with a subtract
// loop in ST_DIV, adds the column offset in ST_OFFS and then walks
// SPRITE_EDGE * SPRITE_EDGE pixels at one sheet read per cycle. Results leave
// at one per cycle on out_valid and must be taken as they come: the receiver
// cannot stall. The sheet is a 16384 x 4 memory with one write and one read
// port.
module sprite_draw_engine_top
  import sde_pkg::*;
#(
  parameter int SPRITE_EDGE          = 8,
  parameter int SHEET_SPRITE_COLUMNS = 16,
  parameter int SHEET_SPRITE_ROWS    = 16,
  parameter int SHEET_PIXEL_WIDTH    = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [13:0]        in_sheet_address,
  input  logic [3:0]         in_sheet_value,
  input  logic [9:0]         in_sprite_id,
  input  logic signed [9:0]  in_pos_x,
  input  logic signed [9:0]  in_pos_y,
  input  logic               in_mirror_x,
  input  logic               in_mirror_y,
  output logic               out_valid,
  output logic signed [10:0] out_dest_x,
  output logic signed [10:0] out_dest_y,
  output logic [15:0]        out_pixel_color,
  output logic               out_write_enable,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int CW = (SPRITE_EDGE > 1) ? $clog2(SPRITE_EDGE) : 1;
  localparam logic [CW-1:0] EDGE_LAST = CW'(SPRITE_EDGE - 1);
  localparam logic [12:0] ID_LIMIT = 13'(SHEET_SPRITE_COLUMNS * SHEET_SPRITE_ROWS);
  localparam logic [9:0] COLS = 10'(SHEET_SPRITE_COLUMNS);
  localparam logic [STORE_AW-1:0] ROW_PITCH = STORE_AW'(SHEET_PIXEL_WIDTH);
  localparam logic [STORE_AW-1:0] SPRITE_ROW_STEP =
    STORE_AW'((SPRITE_EDGE * SHEET_PIXEL_WIDTH) % (2 ** STORE_AW));
  localparam logic [STORE_AW-1:0] MIRROR_OFS =
    STORE_AW'(((SPRITE_EDGE - 1) * SHEET_PIXEL_WIDTH) % (2 ** STORE_AW));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OFFS,
    ST_WALK
  } state_t;

  state_t               state_r, state_nxt;
  logic [9:0]           rem_r, rem_nxt;
  logic [STORE_AW-1:0]  base_r, base_nxt;
  logic                 mx_r, mx_nxt;
  logic                 my_r, my_nxt;
  logic signed [10:0]   posx_r, posx_nxt;
  logic signed [10:0]   dx_r, dx_nxt;
  logic signed [10:0]   dy_r, dy_nxt;
  logic [CW-1:0]        px_r, px_nxt;
  logic [CW-1:0]        py_r, py_nxt;

  logic                 b_valid_r, b_valid_nxt;
  logic signed [10:0]   b_dx_r, b_dx_nxt;
  logic signed [10:0]   b_dy_r, b_dy_nxt;
  logic                 b_on_r, b_on_nxt;
  logic                 b_last_r, b_last_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [10:0]   out_dx_r, out_dx_nxt;
  logic signed [10:0]   out_dy_r, out_dy_nxt;
  logic [15:0]          out_color_r, out_color_nxt;
  logic                 out_we_r, out_we_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [8:0]           width_r, width_nxt;
  logic [8:0]           height_r, height_nxt;
  logic                 swap_r, swap_nxt;
  logic [63:0]          remap_r, remap_nxt;

  logic [3:0]           sheet_mem [2 ** STORE_AW];
  logic [3:0]           rd_data_r;
  logic                 rd_en;
  logic [STORE_AW-1:0]  rd_addr;
  logic                 wr_en;

  logic                 start_acc;
  logic                 cfg_acc;
  logic [CW-1:0]        scol;
  logic                 row_on;
  logic                 col_on;
  logic                 pix_we;
  color_req_t           color_req;
  logic [15:0]          unit_color;

  assign busy      = (state_r != ST_IDLE) || b_valid_r;
  assign start_acc = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign wr_en     = start_acc && !in_action;

  assign scol    = mx_r ? (EDGE_LAST - px_r) : px_r;
  assign rd_addr = base_r + STORE_AW'(scol);
  assign rd_en   = (state_r == ST_WALK);
  assign row_on  = !dy_r[10] && (dy_r[9:0] < {1'b0, height_r});
  assign col_on  = !dx_r[10] && (dx_r[9:0] < {1'b0, width_r});

  assign pix_we          = b_on_r && (rd_data_r != 4'd0);
  assign color_req.index = rd_data_r;
  assign color_req.swap  = swap_r;

  sde_color_unit u_color (
    .remap (remap_r),
    .req   (color_req),
    .color (unit_color)
  );

  always_comb begin
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    base_nxt    = base_r;
    mx_nxt      = mx_r;
    my_nxt      = my_r;
    posx_nxt    = posx_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    px_nxt      = px_r;
    py_nxt      = py_r;

    b_valid_nxt = 1'b0;
    b_dx_nxt    = dx_r;
    b_dy_nxt    = dy_r;
    b_on_nxt    = row_on && col_on;
    b_last_nxt  = (px_r == EDGE_LAST) && (py_r == EDGE_LAST);

    out_valid_nxt = b_valid_r;
    out_dx_nxt    = b_dx_r;
    out_dy_nxt    = b_dy_r;
    out_we_nxt    = pix_we;
    out_color_nxt = pix_we ? unit_color : 16'h0000;
    out_last_nxt  = b_last_r;

    width_nxt  = width_r;
    height_nxt = height_r;
    swap_nxt   = swap_r;
    remap_nxt  = remap_r;

    if (cfg_acc) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SCREEN_WIDTH:  width_nxt  = cfg_data[8:0];
        CFG_SCREEN_HEIGHT: height_nxt = cfg_data[8:0];
        CFG_SWAP_BYTES:    swap_nxt   = cfg_data[0];
        CFG_PALETTE_REMAP: remap_nxt  = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start_acc && in_action) begin
          if ({3'b000, in_sprite_id} >= ID_LIMIT) begin
            out_valid_nxt = 1'b1;
            out_dx_nxt    = '0;
            out_dy_nxt    = '0;
            out_color_nxt = 16'h0000;
            out_we_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
          end else begin
            rem_nxt   = in_sprite_id;
            base_nxt  = in_mirror_y ? MIRROR_OFS : '0;
            mx_nxt    = in_mirror_x;
            my_nxt    = in_mirror_y;
            posx_nxt  = 11'(in_pos_x);
            dx_nxt    = 11'(in_pos_x);
            dy_nxt    = 11'(in_pos_y);
            px_nxt    = '0;
            py_nxt    = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem_r >= COLS) begin
          rem_nxt  = rem_r - COLS;
          base_nxt = base_r + SPRITE_ROW_STEP;
        end else begin
          state_nxt = ST_OFFS;
        end
      end
      ST_OFFS: begin
        base_nxt  = base_r + STORE_AW'(rem_r * 10'(SPRITE_EDGE));
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        b_valid_nxt = 1'b1;
        if (px_r == EDGE_LAST) begin
          px_nxt   = '0;
          py_nxt   = py_r + 1'b1;
          dx_nxt   = posx_r;
          dy_nxt   = dy_r + 11'sd1;
          base_nxt = my_r ? (base_r - ROW_PITCH) : (base_r + ROW_PITCH);
          if (py_r == EDGE_LAST) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          px_nxt = px_r + 1'b1;
          dx_nxt = dx_r + 11'sd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= RST_SCREEN_WIDTH;
      height_r    <= RST_SCREEN_HEIGHT;
      swap_r      <= RST_SWAP_BYTES;
      remap_r     <= RST_PALETTE_REMAP;
    end else begin
      state_r     <= state_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      swap_r      <= swap_nxt;
      remap_r     <= remap_nxt;
    end
    rem_r       <= rem_nxt;
    base_r      <= base_nxt;
    mx_r        <= mx_nxt;
    my_r        <= my_nxt;
    posx_r      <= posx_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    b_dx_r      <= b_dx_nxt;
    b_dy_r      <= b_dy_nxt;
    b_on_r      <= b_on_nxt;
    b_last_r    <= b_last_nxt;
    out_dx_r    <= out_dx_nxt;
    out_dy_r    <= out_dy_nxt;
    out_color_r <= out_color_nxt;
    out_we_r    <= out_we_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sheet_mem[in_sheet_address] <= in_sheet_value;
    end
    if (rd_en) begin
      rd_data_r <= sheet_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_x       = out_dx_r;
  assign out_dest_y       = out_dy_r;
  assign out_pixel_color  = out_color_r;
  assign out_write_enable = out_we_r;
  assign out_last         = out_last_r;

endmodule

/* hdl/sde_checker.sv */
// ----------------------------------------------------------------------------
// Sprite draw engine checker
// Port-level assertions on transaction sequencing and result contents.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sde_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_action,
  input logic               out_valid,
  input logic signed [10:0] out_dest_x,
  input logic signed [10:0] out_dest_y,
  input logic [15:0]        out_pixel_color,
  input logic               out_write_enable,
  input logic               out_last
);

  // A draw either starts a walk or answers at once.
  `ASSERT_NEXT(a_draw_responds, clk, rst_n, start && !busy && in_action, busy || out_valid)
  // A load never produces a result.
  `ASSERT_NEXT(a_load_silent, clk, rst_n, start && !busy && !in_action, !out_valid)
  // The results of one draw arrive back to back.
  `ASSERT_NEXT(a_burst_contiguous, clk, rst_n, out_valid && !out_last, out_valid)
  // Skipped pixels carry no color.
  `ASSERT_IMPL(a_skip_no_color, clk, rst_n, out_valid && !out_write_enable,
               out_pixel_color == 16'h0000)
  // Written pixels lie at non-negative coordinates.
  `ASSERT_IMPL(a_write_on_screen, clk, rst_n, out_valid && out_write_enable,
               !out_dest_x[10] && !out_dest_y[10])

endmodule

bind sprite_draw_engine_top sde_checker u_sde_checker (.*);

/* sim/sprite_draw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite draw engine checker
// Watches the load, draw, register and pixel channels of the sprite draw
// engine, predicts every pixel write from its own copy of the sheet and the
// registers, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module sprite_draw_checker
  import sde_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_action,
  input  logic [13:0]        in_sheet_address,
  input  logic [3:0]         in_sheet_value,
  input  logic [9:0]         in_sprite_id,
  input  logic signed [9:0]  in_pos_x,
  input  logic signed [9:0]  in_pos_y,
  input  logic               in_mirror_x,
  input  logic               in_mirror_y,
  input  logic               out_valid,
  input  logic signed [10:0] out_dest_x,
  input  logic signed [10:0] out_dest_y,
  input  logic [15:0]        out_pixel_color,
  input  logic               out_write_enable,
  input  logic               out_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int EDGE    = 8;
  localparam int COLS    = 16;
  localparam int ROWS    = 16;
  localparam int SHEET_W = 128;
  localparam int REPORT_LIMIT = 10;

  localparam logic [15:0] RGB565_LUT [16] = '{
    16'h0000, 16'h194A, 16'h792A, 16'h0429, 16'hAB49, 16'h5AEB, 16'hC618, 16'hFFDF,
    16'hF809, 16'hFD20, 16'hFFE4, 16'h07E4, 16'h2D7F, 16'h83B3, 16'hFBB5, 16'hFE75
  };

  typedef struct packed {
    logic signed [10:0] dest_x;
    logic signed [10:0] dest_y;
    logic [15:0]        color;
    logic               we;
    logic               last;
  } pixel_write_t;

  pixel_write_t expected_writes[$];
  logic [3:0]   sheet_copy [0:16383];
  logic [8:0]   scr_w;
  logic [8:0]   scr_h;
  logic         swap_bytes;
  logic [63:0]  remap;
  int           fails = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic predict_sprite_writes(input logic [9:0] id, input logic signed [9:0] x0,
                                       input logic signed [9:0] y0, input logic flip_x,
                                       input logic flip_y);
    pixel_write_t w;
    int base_col, base_row, dx, dy, srow, scol;
    logic [13:0] addr;
    logic [3:0] idx;
    logic [15:0] rgb;
    bit on;
    if (int'(id) >= COLS * ROWS) begin
      w = '{dest_x: '0, dest_y: '0, color: '0, we: 1'b0, last: 1'b1};
      expected_writes.push_back(w);
      return;
    end
    base_col = (int'(id) % COLS) * EDGE;
    base_row = (int'(id) / COLS) * EDGE;
    for (int r = 0; r < EDGE; r++) begin
      dy   = int'(y0) + r;
      srow = flip_y ? EDGE - 1 - r : r;
      for (int c = 0; c < EDGE; c++) begin
        dx   = int'(x0) + c;
        scol = flip_x ? EDGE - 1 - c : c;
        on   = dy >= 0 && dy < int'(scr_h) && dx >= 0 && dx < int'(scr_w);
        addr = 14'((base_row + srow) * SHEET_W + base_col + scol);
        idx  = sheet_copy[addr];
        w.dest_x = 11'(dx);
        w.dest_y = 11'(dy);
        w.we     = on && idx != 4'd0;
        w.color  = '0;
        if (w.we) begin
          rgb     = RGB565_LUT[remap[4*idx +: 4]];
          w.color = swap_bytes ? {rgb[7:0], rgb[15:8]} : rgb;
        end
        w.last = (r == EDGE - 1) && (c == EDGE - 1);
        expected_writes.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_write_t got;
    pixel_write_t want;
    if (!rst_n) begin
      scr_w      = RST_SCREEN_WIDTH;
      scr_h      = RST_SCREEN_HEIGHT;
      swap_bytes = RST_SWAP_BYTES;
      remap      = RST_PALETTE_REMAP;
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SCREEN_WIDTH:  scr_w      = cfg_data[8:0];
          CFG_SCREEN_HEIGHT: scr_h      = cfg_data[8:0];
          CFG_SWAP_BYTES:    swap_bytes = cfg_data[0];
          CFG_PALETTE_REMAP: remap      = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (!in_action) begin
          sheet_copy[in_sheet_address] = in_sheet_value;
        end else begin
          predict_sprite_writes(in_sprite_id, in_pos_x, in_pos_y, in_mirror_x, in_mirror_y);
        end
      end
      if (out_valid) begin
        got = '{dest_x: out_dest_x, dest_y: out_dest_y, color: out_pixel_color,
                we: out_write_enable, last: out_last};
        if (expected_writes.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("unexpected pixel write: x=%0d y=%0d color=%h we=%b last=%b",
                     got.dest_x, got.dest_y, got.color, got.we, got.last);
          end
        end else begin
          want = expected_writes.pop_front();
          if (got.dest_x !== want.dest_x || got.dest_y !== want.dest_y ||
              got.color !== want.color || got.we !== want.we || got.last !== want.last) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("pixel write mismatch: expected x=%0d y=%0d color=%h we=%b last=%b",
                       want.dest_x, want.dest_y, want.color, want.we, want.last);
              $display("                      actual   x=%0d y=%0d color=%h we=%b last=%b",
                       got.dest_x, got.dest_y, got.color, got.we, got.last);
            end
          end
        end
      end
    end
    pending_count <= expected_writes.size();
    fail_count    <= fails;
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite draw engine testbench
// Fills sprites on the sheet, draws them at clipped and unclipped positions
// with every mirror combination, and steps through several screen, byte swap
// and remap settings while the checker verifies every pixel write.
// ----------------------------------------------------------------------------
module tb_top
  import sde_pkg::*;
();

  localparam int SPRITE_EDGE          = 8;
  localparam int SHEET_SPRITE_COLUMNS = 16;
  localparam int SHEET_SPRITE_ROWS    = 16;
  localparam int SHEET_PIXEL_WIDTH    = 128;
  localparam int CYCLE_LIMIT          = 1000000;
  localparam int PHASE_ITEMS          = 45;
  localparam int NUM_PHASES           = 6;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_action = 1'b0;
  logic [13:0]        in_sheet_address = '0;
  logic [3:0]         in_sheet_value = '0;
  logic [9:0]         in_sprite_id = '0;
  logic signed [9:0]  in_pos_x = '0;
  logic signed [9:0]  in_pos_y = '0;
  logic               in_mirror_x = 1'b0;
  logic               in_mirror_y = 1'b0;
  logic               out_valid;
  logic signed [10:0] out_dest_x;
  logic signed [10:0] out_dest_y;
  logic [15:0]        out_pixel_color;
  logic               out_write_enable;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending_count;

  int cycle_count = 0;
  int items_sent  = 0;
  int no_gap_left = 0;
  int cur_w = 256;
  int cur_h = 150;
  int ready_ids[$];
  bit loaded_sprite [SHEET_SPRITE_COLUMNS * SHEET_SPRITE_ROWS];

  always #6 clk = ~clk;

  sprite_draw_engine_top #(
    .SPRITE_EDGE          (SPRITE_EDGE),
    .SHEET_SPRITE_COLUMNS (SHEET_SPRITE_COLUMNS),
    .SHEET_SPRITE_ROWS    (SHEET_SPRITE_ROWS),
    .SHEET_PIXEL_WIDTH    (SHEET_PIXEL_WIDTH)
  ) dut (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_sheet_address, .in_sheet_value, .in_sprite_id,
    .in_pos_x, .in_pos_y, .in_mirror_x, .in_mirror_y,
    .out_valid, .out_dest_x, .out_dest_y, .out_pixel_color, .out_write_enable, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sprite_draw_checker checker_i (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_sheet_address, .in_sheet_value, .in_sprite_id,
    .in_pos_x, .in_pos_y, .in_mirror_x, .in_mirror_y,
    .out_valid, .out_dest_x, .out_dest_y, .out_pixel_color, .out_write_enable, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_count
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sprite_draw_engine_top verification failed");
      $finish;
    end
  end

  task automatic send_transaction(input logic action, input logic [13:0] addr,
                                  input logic [3:0] val, input logic [9:0] id,
                                  input logic signed [9:0] x, input logic signed [9:0] y,
                                  input logic fx, input logic fy);
    int gap;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 15) == 0) no_gap_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_action        <= action;
    in_sheet_address <= addr;
    in_sheet_value   <= val;
    in_sprite_id     <= id;
    in_pos_x         <= x;
    in_pos_y         <= y;
    in_mirror_x      <= fx;
    in_mirror_y      <= fy;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_pixel(input int addr, input int val);
    send_transaction(1'b0, 14'(addr), 4'(val), 10'($urandom), 10'($urandom), 10'($urandom),
                     1'($urandom), 1'($urandom));
  endtask

  task automatic draw_sprite(input int id, input int x, input int y, input bit fx,
                             input bit fy);
    send_transaction(1'b1, 14'($urandom), 4'($urandom), 10'(id), 10'(x), 10'(y), fx, fy);
  endtask

  task automatic fill_sprite(input int id);
    int addr;
    for (int r = 0; r < SPRITE_EDGE; r++) begin
      for (int c = 0; c < SPRITE_EDGE; c++) begin
        addr = ((id / SHEET_SPRITE_COLUMNS) * SPRITE_EDGE + r) * SHEET_PIXEL_WIDTH
               + (id % SHEET_SPRITE_COLUMNS) * SPRITE_EDGE + c;
        load_pixel(addr, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15));
      end
    end
    loaded_sprite[id] = 1'b1;
    ready_ids.push_back(id);
  endtask

  function automatic int pick_coord(input int extent);
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = int'($urandom_range(0, 1023)) - 512;
    end else begin
      v = int'($urandom_range(0, extent + 8)) - 8;
      if (v > 511) v = 511;
    end
    return v;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input int w, input int h, input bit swap, input logic [63:0] map);
    logic [63:0] junk;
    logic [63:0] data;
    cfg_reg_t idx;
    for (int i = 0; i < 4; i++) begin
      idx  = cfg_reg_t'(i);
      junk = {$urandom, $urandom};
      case (idx)
        CFG_SCREEN_WIDTH:  data = {junk[63:9], 9'(w)};
        CFG_SCREEN_HEIGHT: data = {junk[63:9], 9'(h)};
        CFG_SWAP_BYTES:    data = {junk[63:1], swap};
        default:           data = map;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic random_phase();
    int target, r, id;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      id = $urandom_range(0, SHEET_SPRITE_COLUMNS * SHEET_SPRITE_ROWS - 1);
      if (r < 4 && ready_ids.size() < 4 && !loaded_sprite[id]) begin
        fill_sprite(id);
      end else if (r < 14) begin
        load_pixel($urandom_range(0, 16383), $urandom_range(0, 15));
      end else if (r < 22) begin
        draw_sprite($urandom_range(SHEET_SPRITE_COLUMNS * SHEET_SPRITE_ROWS, 1023),
                    pick_coord(cur_w), pick_coord(cur_h), $urandom_range(0, 1),
                    $urandom_range(0, 1));
      end else begin
        draw_sprite(ready_ids[$urandom_range(0, ready_ids.size() - 1)],
                    pick_coord(cur_w), pick_coord(cur_h), $urandom_range(0, 1),
                    $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fill_sprite(0);
    fill_sprite(255);
    load_pixel(0, 15);
    load_pixel(7, 0);
    load_pixel(16383, 0);
    draw_sprite(1023, 5, 5, 1'b0, 1'b0);
    draw_sprite(256, -1, -1, 1'b1, 1'b1);
    draw_sprite(0, 0, 0, 1'b0, 1'b0);
    draw_sprite(0, 0, 0, 1'b1, 1'b0);
    draw_sprite(0, 0, 0, 1'b0, 1'b1);
    draw_sprite(0, 0, 0, 1'b1, 1'b1);
    draw_sprite(255, -4, -4, 1'b0, 1'b0);
    draw_sprite(255, 252, 146, 1'b1, 1'b1);
    draw_sprite(255, 248, 142, 1'b0, 1'b1);
    draw_sprite(255, -512, -512, 1'b1, 1'b0);
    draw_sprite(255, 511, 511, 1'b0, 1'b0);
    draw_sprite(255, -8, 0, 1'b0, 1'b0);
    draw_sprite(0, 0, -8, 1'b0, 1'b0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: write_config(256, 256, 1'b1, {$urandom, $urandom});
        1: write_config(1, 1, 1'b0, 64'h0);
        2: write_config(0, 0, 1'b1, '1);
        3: write_config(511, 511, 1'b0, {$urandom, $urandom});
        default: write_config($urandom_range(1, 256), $urandom_range(1, 256),
                              $urandom_range(0, 1), {$urandom, $urandom});
      endcase
      random_phase();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("sprite_draw_engine_top verification clean");
    end else begin
      $display("sprite_draw_engine_top verification failed");
    end
    $finish;
  end

endmodule

/* sprite_draw_engine_top.f */
+incdir+hdl
hdl/sde_pkg.sv
hdl/sde_color_unit.sv
hdl/sprite_draw_engine_top.sv
hdl/sde_checker.sv
sim/sprite_draw_checker.sv
sim/tb_top.sv
